/* hw/rtl/spdh_pkg.sv */
// Shared types and constants of the shortest-path engine.
// No dependencies; the controller, datapath, top level and test files refer to it by scoped names.
package spdh_pkg;

    localparam int COST_W = 31;
    localparam int PRED_W = 7;
    localparam logic [COST_W-1:0] COST_INF = 31'h7FFF_FFFF;
    localparam logic signed [PRED_W-1:0] PRED_NONE = -7'sd1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_RUN   = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_INIT,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_LOOP,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_KEY,
        S_SIFT_CHK,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_DEC,
        S_VISIT,
        S_HEAD_GET,
        S_EDGE_CHK,
        S_EDGE_GET,
        S_BEST_GET,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        state_t op;
        logic   in_ready;
    } cmd_t;

    typedef struct packed {
        logic  in_take;
        kind_t in_kind;
        logic  src_bad;
        logic  pos_zero;
        logic  key_lt_parent;
        logic  lc_in;
        logic  rc_in;
        logic  sift_stay;
        logic  u_skip;
        logic  e_null;
        logic  relax_push;
        logic  size_zero;
        logic  out_last;
        logic  out_taken;
    } stat_t;

endpackage

/* hw/rtl/spdh_in_if.sv */
// Input channel of the shortest-path engine: valid/ready plus one command beat.
// Depends on nothing.
interface spdh_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  from_vertex;
    logic [5:0]  to_vertex;
    logic [15:0] weight;

    modport source (output valid, kind, from_vertex, to_vertex, weight, input ready);
    modport sink (input valid, kind, from_vertex, to_vertex, weight, output ready);
endinterface

/* hw/rtl/spdh_out_if.sv */
// Result channel of the shortest-path engine: valid/ready plus one result beat.
// Depends on nothing.
interface spdh_out_if;
    logic              valid;
    logic              ready;
    logic [5:0]        vertex;
    logic [30:0]       cost;
    logic signed [6:0] predecessor;
    logic              reached;
    logic              edges_dropped;
    logic              last;

    modport source (output valid, vertex, cost, predecessor, reached, edges_dropped, last,
                    input ready);
    modport sink (input valid, vertex, cost, predecessor, reached, edges_dropped, last,
                  output ready);
endinterface

/* hw/rtl/spdh_ctrl.sv */
// Sequencer of the shortest-path engine: walks add, heap, edge and result steps.
// Depends on spdh_pkg; drives commands into spdh_dp and reads its status.
module spdh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  spdh_pkg::stat_t stat,
    output spdh_pkg::cmd_t  cmd
);

    spdh_pkg::state_t state_reg;
    spdh_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spdh_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = state_reg;
        cmd.in_ready = (state_reg == spdh_pkg::S_IDLE);
        case (state_reg)
            spdh_pkg::S_IDLE:
            begin
                if (stat.in_take)
                begin
                    case (stat.in_kind)
                        spdh_pkg::KIND_ADD: state_next = spdh_pkg::S_ADD_RD;
                        spdh_pkg::KIND_RUN: state_next = spdh_pkg::S_INIT;
                        default:            state_next = spdh_pkg::S_IDLE;
                    endcase
                end
            end
            spdh_pkg::S_ADD_RD: state_next = spdh_pkg::S_ADD_WR;
            spdh_pkg::S_ADD_WR: state_next = spdh_pkg::S_IDLE;
            spdh_pkg::S_INIT:
            begin
                state_next = stat.src_bad ? spdh_pkg::S_OUT_RD : spdh_pkg::S_PUSH_CHK;
            end
            spdh_pkg::S_PUSH_CHK:
            begin
                state_next = stat.pos_zero ? spdh_pkg::S_EDGE_CHK : spdh_pkg::S_PUSH_CMP;
            end
            spdh_pkg::S_PUSH_CMP:
            begin
                state_next = stat.key_lt_parent ? spdh_pkg::S_PUSH_CHK : spdh_pkg::S_EDGE_CHK;
            end
            spdh_pkg::S_LOOP:
            begin
                state_next = stat.size_zero ? spdh_pkg::S_OUT_RD : spdh_pkg::S_POP_RD0;
            end
            spdh_pkg::S_POP_RD0: state_next = spdh_pkg::S_POP_RDL;
            spdh_pkg::S_POP_RDL: state_next = spdh_pkg::S_POP_KEY;
            spdh_pkg::S_POP_KEY: state_next = spdh_pkg::S_SIFT_CHK;
            spdh_pkg::S_SIFT_CHK:
            begin
                state_next = stat.lc_in ? spdh_pkg::S_SIFT_L : spdh_pkg::S_VISIT;
            end
            spdh_pkg::S_SIFT_L:
            begin
                state_next = stat.rc_in ? spdh_pkg::S_SIFT_R : spdh_pkg::S_SIFT_DEC;
            end
            spdh_pkg::S_SIFT_R: state_next = spdh_pkg::S_SIFT_DEC;
            spdh_pkg::S_SIFT_DEC:
            begin
                state_next = stat.sift_stay ? spdh_pkg::S_VISIT : spdh_pkg::S_SIFT_CHK;
            end
            spdh_pkg::S_VISIT:
            begin
                state_next = stat.u_skip ? spdh_pkg::S_LOOP : spdh_pkg::S_HEAD_GET;
            end
            spdh_pkg::S_HEAD_GET: state_next = spdh_pkg::S_EDGE_CHK;
            spdh_pkg::S_EDGE_CHK:
            begin
                state_next = stat.e_null ? spdh_pkg::S_LOOP : spdh_pkg::S_EDGE_GET;
            end
            spdh_pkg::S_EDGE_GET: state_next = spdh_pkg::S_BEST_GET;
            spdh_pkg::S_BEST_GET:
            begin
                state_next = stat.relax_push ? spdh_pkg::S_PUSH_CHK : spdh_pkg::S_EDGE_CHK;
            end
            spdh_pkg::S_OUT_RD:   state_next = spdh_pkg::S_OUT_LOAD;
            spdh_pkg::S_OUT_LOAD: state_next = spdh_pkg::S_OUT_WAIT;
            spdh_pkg::S_OUT_WAIT:
            begin
                if (stat.out_taken)
                begin
                    state_next = stat.out_last ? spdh_pkg::S_IDLE : spdh_pkg::S_OUT_RD;
                end
            end
            default: state_next = spdh_pkg::S_IDLE;
        endcase
    end

endmodule

/* hw/rtl/spdh_dp.sv */
// Datapath of the shortest-path engine: edge store, list heads, cost table,
// binary heap memory and result register. Depends on spdh_pkg and the interfaces.
module spdh_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [6:0]        cfg_data,
    spdh_in_if.sink           items,
    spdh_out_if.source        results,
    input  spdh_pkg::cmd_t    cmd,
    output spdh_pkg::stat_t   stat
);

    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int NW         = VW + 1;
    localparam int EW         = $clog2(MAX_EDGES + 1);
    localparam int EAW        = $clog2(MAX_EDGES);
    localparam int HEAP_DEPTH = MAX_EDGES + 1;
    localparam int HIW        = $clog2(HEAP_DEPTH);
    localparam int HSW        = $clog2(HEAP_DEPTH + 1);
    localparam int CW         = spdh_pkg::COST_W;
    localparam int PW         = spdh_pkg::PRED_W;
    localparam int HEW        = VW + CW;
    localparam int EDW        = VW + WEIGHT_BITS + EW;
    localparam int BW         = CW + PW;
    localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);

    logic [6:0]             vcount_reg;
    logic [EW-1:0]          ecount_reg;
    logic                   dropped_reg;
    logic [MAX_VERTICES-1:0] head_vld_reg;
    logic [MAX_VERTICES-1:0] best_vld_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [HSW-1:0]         size_reg;
    logic                   out_valid_reg;

    logic [NW-1:0]          nv_reg;
    logic [5:0]             from_reg;
    logic [5:0]             to_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [HIW-1:0]         pos_reg;
    logic [HEW-1:0]         key_reg;
    logic [VW-1:0]          u_reg;
    logic [CW-1:0]          cu_reg;
    logic [EW-1:0]          e_reg;
    logic [VW-1:0]          t_reg;
    logic [WEIGHT_BITS-1:0] ew_reg;
    logic [HEW-1:0]         cl_reg;
    logic [HEW-1:0]         cr_reg;
    logic                   have_r_reg;
    logic [VW-1:0]          v_reg;
    logic [5:0]             o_vertex_reg;
    logic [CW-1:0]          o_cost_reg;
    logic signed [PW-1:0]   o_pred_reg;
    logic                   o_reached_reg;
    logic                   o_dropped_reg;
    logic                   o_last_reg;

    logic [EW-1:0]  head_mem [MAX_VERTICES];
    logic [EW-1:0]  head_q;
    logic [EDW-1:0] edge_mem [MAX_EDGES];
    logic [EDW-1:0] edge_q;
    logic [BW-1:0]  best_mem [MAX_VERTICES];
    logic [BW-1:0]  best_q;
    logic [HEW-1:0] heap_mem [HEAP_DEPTH];
    logic [HEW-1:0] heap_q;

    logic                   in_take;
    logic [NW-1:0]          nv_in;
    logic [VW-1:0]          from_idx;
    logic [VW-1:0]          to_idx;
    logic                   from_ok;
    logic                   to_ok;
    logic                   edge_full;
    logic                   add_ok;
    logic                   src_bad;
    logic [EW-1:0]          head_rd;
    logic [VW-1:0]          head_ra;
    logic [VW-1:0]          edge_tgt;
    logic [WEIGHT_BITS-1:0] edge_wt;
    logic [EW-1:0]          edge_nxt;
    logic [VW-1:0]          best_ra;
    logic [CW-1:0]          best_cost_rd;
    logic [CW-1:0]          key_cost;
    logic [HIW-1:0]         parent;
    logic [HIW:0]           lc_w;
    logic [HIW:0]           rc_w;
    logic                   lc_in;
    logic                   rc_in;
    logic                   key_lt_parent;
    logic                   l_lt;
    logic                   r_lt;
    logic [CW-1:0]          min_cost;
    logic                   sift_stay;
    logic [HEW-1:0]         child;
    logic [HIW-1:0]         child_idx;
    logic                   t_bad;
    logic [CW:0]            sum;
    logic [CW-1:0]          nc;
    logic                   relax_take;
    logic                   heap_full;
    logic                   u_skip;
    logic                   out_last;
    logic                   out_taken;
    logic                   heap_we;
    logic [HIW-1:0]         heap_wa;
    logic [HEW-1:0]         heap_wd;
    logic [HIW-1:0]         heap_ra;

    assign in_take   = items.valid & cmd.in_ready;
    assign out_taken = out_valid_reg & results.ready;

    assign nv_in = (vcount_reg == 7'd0) ? NW'(1)
                 : (vcount_reg > 7'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vcount_reg);

    assign from_idx  = VW'(from_reg);
    assign to_idx    = VW'(to_reg);
    assign from_ok   = 32'(from_reg) < 32'(MAX_VERTICES);
    assign to_ok     = 32'(to_reg) < 32'(MAX_VERTICES);
    assign edge_full = 32'(ecount_reg) >= 32'(MAX_EDGES);
    assign add_ok    = from_ok & to_ok & ~edge_full;
    assign src_bad   = 7'(from_reg) >= 7'(nv_reg);

    assign head_rd = head_vld_reg[head_ra] ? head_q : EDGE_NULL;
    assign head_ra = (cmd.op == spdh_pkg::S_HEAD_GET || cmd.op == spdh_pkg::S_VISIT)
                   ? u_reg : from_idx;

    assign {edge_tgt, edge_wt, edge_nxt} = edge_q;

    assign best_ra      = (cmd.op == spdh_pkg::S_EDGE_GET) ? edge_tgt : v_reg;
    assign best_cost_rd = best_vld_reg[t_reg] ? best_q[BW-1:PW] : spdh_pkg::COST_INF;

    assign key_cost      = key_reg[CW-1:0];
    assign parent        = HIW'((pos_reg - HIW'(1)) >> 1);
    assign lc_w          = {pos_reg, 1'b1};
    assign rc_w          = lc_w + (HIW+1)'(1);
    assign lc_in         = (HIW+2)'(lc_w) < (HIW+2)'(size_reg);
    assign rc_in         = (HIW+2)'(rc_w) < (HIW+2)'(size_reg);
    assign key_lt_parent = key_cost < heap_q[CW-1:0];

    assign l_lt      = cl_reg[CW-1:0] < key_cost;
    assign min_cost  = l_lt ? cl_reg[CW-1:0] : key_cost;
    assign r_lt      = have_r_reg & (cr_reg[CW-1:0] < min_cost);
    assign sift_stay = ~l_lt & ~r_lt;
    assign child     = r_lt ? cr_reg : cl_reg;
    assign child_idx = r_lt ? HIW'(rc_w) : HIW'(lc_w);

    assign t_bad      = 7'(t_reg) >= 7'(nv_reg);
    assign sum        = (CW+1)'(cu_reg) + (CW+1)'(ew_reg);
    assign nc         = (sum > (CW+1)'(spdh_pkg::COST_INF)) ? spdh_pkg::COST_INF : sum[CW-1:0];
    assign relax_take = ~t_bad & ~visited_reg[t_reg] & (nc < best_cost_rd);
    assign heap_full  = size_reg == HSW'(HEAP_DEPTH);
    assign u_skip     = (32'(u_reg) >= 32'(MAX_VERTICES)) | visited_reg[u_reg];
    assign out_last   = 7'(v_reg) == (7'(nv_reg) - 7'd1);

    always_comb
    begin
        stat.in_take       = in_take;
        stat.in_kind       = spdh_pkg::kind_t'(items.kind);
        stat.src_bad       = src_bad;
        stat.pos_zero      = pos_reg == '0;
        stat.key_lt_parent = key_lt_parent;
        stat.lc_in         = lc_in;
        stat.rc_in         = rc_in;
        stat.sift_stay     = sift_stay;
        stat.u_skip        = u_skip;
        stat.e_null        = 32'(e_reg) >= 32'(MAX_EDGES);
        stat.relax_push    = relax_take & ~heap_full;
        stat.size_zero     = size_reg == '0;
        stat.out_last      = out_last;
        stat.out_taken     = out_taken;
    end

    always_comb
    begin
        heap_we = 1'b0;
        heap_wa = pos_reg;
        heap_wd = key_reg;
        heap_ra = '0;
        case (cmd.op)
            spdh_pkg::S_PUSH_CHK:
            begin
                heap_we = (pos_reg == '0);
                heap_ra = parent;
            end
            spdh_pkg::S_PUSH_CMP:
            begin
                heap_we = 1'b1;
                heap_wd = key_lt_parent ? heap_q : key_reg;
            end
            spdh_pkg::S_POP_RDL:
            begin
                heap_ra = HIW'(size_reg - HSW'(1));
            end
            spdh_pkg::S_SIFT_CHK:
            begin
                heap_we = ~lc_in;
                heap_ra = HIW'(lc_w);
            end
            spdh_pkg::S_SIFT_L:
            begin
                heap_ra = HIW'(rc_w);
            end
            spdh_pkg::S_SIFT_DEC:
            begin
                heap_we = 1'b1;
                heap_wd = sift_stay ? key_reg : child;
            end
            default:
            begin
                heap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= 7'd64;
            ecount_reg    <= '0;
            dropped_reg   <= 1'b0;
            head_vld_reg  <= '0;
            best_vld_reg  <= '0;
            visited_reg   <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                vcount_reg <= cfg_data;
            end
            case (cmd.op)
                spdh_pkg::S_IDLE:
                begin
                    if (in_take && items.kind == spdh_pkg::KIND_CLEAR)
                    begin
                        head_vld_reg <= '0;
                        ecount_reg   <= '0;
                        dropped_reg  <= 1'b0;
                    end
                end
                spdh_pkg::S_ADD_WR:
                begin
                    if (from_ok && to_ok)
                    begin
                        if (edge_full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            head_vld_reg[from_idx] <= 1'b1;
                            ecount_reg             <= ecount_reg + EW'(1);
                        end
                    end
                end
                spdh_pkg::S_INIT:
                begin
                    visited_reg <= '0;
                    if (src_bad)
                    begin
                        best_vld_reg <= '0;
                        size_reg     <= '0;
                    end
                    else
                    begin
                        best_vld_reg <= MAX_VERTICES'(1) << from_idx;
                        size_reg     <= HSW'(1);
                    end
                end
                spdh_pkg::S_BEST_GET:
                begin
                    if (relax_take)
                    begin
                        best_vld_reg[t_reg] <= 1'b1;
                        if (!heap_full)
                        begin
                            size_reg <= size_reg + HSW'(1);
                        end
                    end
                end
                spdh_pkg::S_POP_KEY:
                begin
                    size_reg <= size_reg - HSW'(1);
                end
                spdh_pkg::S_VISIT:
                begin
                    if (!u_skip)
                    begin
                        visited_reg[u_reg] <= 1'b1;
                    end
                end
                spdh_pkg::S_OUT_LOAD:
                begin
                    out_valid_reg <= 1'b1;
                end
                spdh_pkg::S_OUT_WAIT:
                begin
                    if (out_taken)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    out_valid_reg <= out_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            spdh_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    from_reg <= items.from_vertex;
                    to_reg   <= items.to_vertex;
                    w_reg    <= WEIGHT_BITS'(items.weight);
                    nv_reg   <= nv_in;
                end
            end
            spdh_pkg::S_INIT:
            begin
                key_reg <= {from_idx, {CW{1'b0}}};
                pos_reg <= '0;
                e_reg   <= EDGE_NULL;
                v_reg   <= '0;
            end
            spdh_pkg::S_PUSH_CMP:
            begin
                if (key_lt_parent)
                begin
                    pos_reg <= parent;
                end
            end
            spdh_pkg::S_EDGE_GET:
            begin
                t_reg  <= edge_tgt;
                ew_reg <= edge_wt;
                e_reg  <= edge_nxt;
            end
            spdh_pkg::S_BEST_GET:
            begin
                key_reg <= {t_reg, nc};
                pos_reg <= HIW'(size_reg);
            end
            spdh_pkg::S_POP_RDL:
            begin
                u_reg  <= heap_q[HEW-1:CW];
                cu_reg <= heap_q[CW-1:0];
            end
            spdh_pkg::S_POP_KEY:
            begin
                key_reg <= heap_q;
                pos_reg <= '0;
            end
            spdh_pkg::S_SIFT_L:
            begin
                cl_reg     <= heap_q;
                have_r_reg <= rc_in;
            end
            spdh_pkg::S_SIFT_R:
            begin
                cr_reg <= heap_q;
            end
            spdh_pkg::S_SIFT_DEC:
            begin
                if (!sift_stay)
                begin
                    pos_reg <= child_idx;
                end
            end
            spdh_pkg::S_HEAD_GET:
            begin
                e_reg <= head_rd;
            end
            spdh_pkg::S_OUT_LOAD:
            begin
                o_vertex_reg  <= 6'(v_reg);
                o_cost_reg    <= best_vld_reg[v_reg] ? best_q[BW-1:PW] : spdh_pkg::COST_INF;
                o_pred_reg    <= best_vld_reg[v_reg] ? best_q[PW-1:0] : spdh_pkg::PRED_NONE;
                o_reached_reg <= best_vld_reg[v_reg] &&
                                 (best_q[BW-1:PW] < spdh_pkg::COST_INF);
                o_dropped_reg <= dropped_reg;
                o_last_reg    <= out_last;
            end
            spdh_pkg::S_OUT_WAIT:
            begin
                if (out_taken && !out_last)
                begin
                    v_reg <= v_reg + VW'(1);
                end
            end
            default:
            begin
                u_reg <= u_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spdh_pkg::S_ADD_WR && add_ok)
        begin
            head_mem[from_idx] <= ecount_reg;
        end
        head_q <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spdh_pkg::S_ADD_WR && add_ok)
        begin
            edge_mem[ecount_reg[EAW-1:0]] <= {to_idx, w_reg, head_rd};
        end
        edge_q <= edge_mem[e_reg[EAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spdh_pkg::S_INIT && !src_bad)
        begin
            best_mem[from_idx] <= {{CW{1'b0}}, spdh_pkg::PRED_NONE};
        end
        else if (cmd.op == spdh_pkg::S_BEST_GET && relax_take)
        begin
            best_mem[t_reg] <= {nc, PW'(u_reg)};
        end
        best_q <= best_mem[best_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_q <= heap_mem[heap_ra];
    end

    assign items.ready           = cmd.in_ready;
    assign results.valid         = out_valid_reg;
    assign results.vertex        = o_vertex_reg;
    assign results.cost          = o_cost_reg;
    assign results.predecessor   = o_pred_reg;
    assign results.reached       = o_reached_reg;
    assign results.edges_dropped = o_dropped_reg;
    assign results.last          = o_last_reg;

`ifndef NO_ASSERTIONS
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(size_reg) <= 32'(HEAP_DEPTH))
        else $error("heap size beyond depth");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ecount_reg) <= 32'(MAX_EDGES))
        else $error("edge count beyond store");

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cmd.op == spdh_pkg::S_OUT_WAIT))
        else $error("result shown outside result phase");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == spdh_pkg::S_POP_RD0) |-> (size_reg != '0))
        else $error("pop from empty heap");
`endif

endmodule

/* hw/rtl/shortest_path_dijkstra_heap.sv */
// Top level of the single-source shortest-path engine (binary heap, lazy deletion).
// Depends on spdh_pkg, spdh_in_if, spdh_out_if, spdh_ctrl and spdh_dp.
//
//  channel   dir  handshake      beat
//  items     in   valid/ready    kind, from_vertex, to_vertex, weight
//  results   out  valid/ready    vertex, cost, predecessor, reached, edges_dropped, last
//  cfg       in   cfg_write      cfg_data = vertex_count
//
// A clear is done in the idle state; an add reads the list head, then writes the edge. A run
// pops the heap with a sift-down, walks the edges of each newly visited vertex, pushes
// improved costs with a sift-up, and at the end hands out one result per vertex.
// Reset empties the graph and sets vertex_count to 64; no clearing pass.
// A stalled result holds the engine in its result phase; items are taken only when idle.
module shortest_path_dijkstra_heap #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [6:0]  cfg_data,
    spdh_in_if.sink     items,
    spdh_out_if.source  results
);

    spdh_pkg::cmd_t  cmd;
    spdh_pkg::stat_t stat;

    spdh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    spdh_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .items     (items),
        .results   (results),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* test/spdh_checker.sv */
`timescale 1ns / 100ps
// Watches the item, result and register ports of the shortest-path engine and predicts every beat.
// Depends on spdh_pkg, spdh_in_if and spdh_out_if.
module spdh_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_write,
    input  logic [6:0] cfg_data,
    spdh_in_if     items,
    spdh_out_if    results,
    output int     pending,
    output int     fails,
    output int     beats_checked
);

    typedef struct {
        logic [5:0]                  vertex;
        logic [spdh_pkg::COST_W-1:0] cost;
        logic signed [6:0]           pred;
        logic                        reached;
        logic                        dropped;
        logic                        last;
    } path_beat_t;

    path_beat_t expected_paths[$];

    int unsigned vcount = 64;
    int unsigned e_target[MAX_EDGES];
    int unsigned e_weight[MAX_EDGES];
    int unsigned e_next[MAX_EDGES];
    int unsigned head[MAX_VERTICES];
    int unsigned n_edges = 0;
    bit          dropped = 0;
    longint unsigned best_c[MAX_VERTICES];
    int          prev_v[MAX_VERTICES];
    bit          done_v[MAX_VERTICES];
    int unsigned hp_v[MAX_EDGES+1];
    longint unsigned hp_c[MAX_EDGES+1];
    int unsigned hp_n;

    initial begin
        fails = 0;
        beats_checked = 0;
        for (int v = 0; v < MAX_VERTICES; v++)
            head[v] = MAX_EDGES;
    end

    assign pending = expected_paths.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    task automatic heap_insert(input int unsigned vtx, input longint unsigned c);
        int unsigned pos;
        if (hp_n >= MAX_EDGES + 1)
            return;
        pos = hp_n;
        hp_n++;
        while (pos != 0 && c < hp_c[(pos-1)/2]) begin
            hp_v[pos] = hp_v[(pos-1)/2];
            hp_c[pos] = hp_c[(pos-1)/2];
            pos = (pos-1)/2;
        end
        hp_v[pos] = vtx;
        hp_c[pos] = c;
    endtask

    task automatic heap_take(output int unsigned vtx);
        int unsigned pos, sm, lc, rc, tv;
        longint unsigned tc;
        vtx = hp_v[0];
        pos = 0;
        hp_n--;
        hp_v[0] = hp_v[hp_n];
        hp_c[0] = hp_c[hp_n];
        forever begin
            sm = pos;
            lc = 2*pos + 1;
            rc = 2*pos + 2;
            if (lc < hp_n && hp_c[lc] < hp_c[sm]) sm = lc;
            if (rc < hp_n && hp_c[rc] < hp_c[sm]) sm = rc;
            if (sm == pos) break;
            tv = hp_v[pos]; tc = hp_c[pos];
            hp_v[pos] = hp_v[sm]; hp_c[pos] = hp_c[sm];
            hp_v[sm] = tv; hp_c[sm] = tc;
            pos = sm;
        end
    endtask

    task automatic solve_paths(input int unsigned src);
        int unsigned nv, u, e, t;
        longint unsigned nc;
        path_beat_t b;
        nv = vcount;
        if (nv == 0) nv = 1;
        if (nv > MAX_VERTICES) nv = MAX_VERTICES;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            best_c[v] = spdh_pkg::COST_INF;
            prev_v[v] = -1;
            done_v[v] = 0;
        end
        hp_n = 0;
        if (src < nv) begin
            best_c[src] = 0;
            heap_insert(src, 0);
            while (hp_n > 0) begin
                heap_take(u);
                if (u >= MAX_VERTICES || done_v[u]) continue;
                done_v[u] = 1;
                e = head[u];
                while (e < MAX_EDGES) begin
                    t = e_target[e];
                    if (t < nv && !done_v[t]) begin
                        nc = best_c[u] + e_weight[e];
                        if (nc > spdh_pkg::COST_INF) nc = spdh_pkg::COST_INF;
                        if (nc < best_c[t]) begin
                            best_c[t] = nc;
                            prev_v[t] = u;
                            heap_insert(t, nc);
                        end
                    end
                    e = e_next[e];
                end
            end
        end
        for (int v = 0; v < nv; v++) begin
            b.vertex  = 6'(v);
            b.cost    = spdh_pkg::COST_W'(best_c[v]);
            b.pred    = 7'(prev_v[v]);
            b.reached = best_c[v] < spdh_pkg::COST_INF;
            b.dropped = dropped;
            b.last    = (v + 1 == nv);
            expected_paths.push_back(b);
        end
    endtask

    task automatic apply_item();
        int unsigned f, t, w;
        f = items.from_vertex;
        t = items.to_vertex;
        w = items.weight & ((1 << WEIGHT_BITS) - 1);
        case (items.kind)
            spdh_pkg::KIND_CLEAR: begin
                for (int v = 0; v < MAX_VERTICES; v++)
                    head[v] = MAX_EDGES;
                n_edges = 0;
                dropped = 0;
            end
            spdh_pkg::KIND_ADD: begin
                if (f < MAX_VERTICES && t < MAX_VERTICES) begin
                    if (n_edges >= MAX_EDGES)
                        dropped = 1;
                    else begin
                        e_target[n_edges] = t;
                        e_weight[n_edges] = w;
                        e_next[n_edges] = head[f];
                        head[f] = n_edges;
                        n_edges++;
                    end
                end
            end
            spdh_pkg::KIND_RUN: solve_paths(f);
            default: ;
        endcase
    endtask

    task automatic check_beat();
        path_beat_t x;
        beats_checked++;
        if (expected_paths.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat for vertex %0d", results.vertex));
            return;
        end
        x = expected_paths.pop_front();
        if (results.vertex !== x.vertex)
            report_mismatch($sformatf("vertex %0d, want %0d", results.vertex, x.vertex));
        if (results.cost !== x.cost)
            report_mismatch($sformatf("v%0d cost %0d, want %0d", x.vertex, results.cost, x.cost));
        if (results.predecessor !== x.pred)
            report_mismatch($sformatf("v%0d predecessor %0d, want %0d", x.vertex,
                                      results.predecessor, x.pred));
        if (results.reached !== x.reached)
            report_mismatch($sformatf("v%0d reached %b, want %b", x.vertex,
                                      results.reached, x.reached));
        if (results.edges_dropped !== x.dropped)
            report_mismatch($sformatf("v%0d edges_dropped %b, want %b", x.vertex,
                                      results.edges_dropped, x.dropped));
        if (results.last !== x.last)
            report_mismatch($sformatf("v%0d last %b, want %b", x.vertex, results.last, x.last));
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (results.valid && results.ready)
                check_beat();
            if (cfg_write)
                vcount = cfg_data;
            if (items.valid && items.ready)
                apply_item();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for the shortest-path engine; spdh_checker does all prediction.
// Depends on spdh_pkg, spdh_in_if, spdh_out_if, spdh_checker and the engine itself.
module tb_top;

    localparam int CYCLE_LIMIT = 3000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [6:0] cfg_data = 7'd0;
    int         pending, fails, beats_checked;
    int         cycles = 0;
    int         items_sent = 0;
    int         runs_sent = 0;

    spdh_in_if  items();
    spdh_out_if results();

    initial begin
        items.valid = 1'b0;
        items.kind = spdh_pkg::KIND_CLEAR;
        items.from_vertex = '0;
        items.to_vertex = '0;
        items.weight = '0;
        results.ready = 1'b0;
    end

    always #2 clk = ~clk;

    shortest_path_dijkstra_heap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .items     (items),
        .results   (results)
    );

    spdh_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .items         (items),
        .results       (results),
        .pending       (pending),
        .fails         (fails),
        .beats_checked (beats_checked)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL shortest_path_dijkstra_heap");
            $finish;
        end
    end

    // result side: random stall per beat, no stall in some phases, one long hold-off to back up the engine
    initial begin
        int n;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever begin
            if (taken == 150)
                n = 600;
            else if ((taken / 40) % 3 == 1)
                n = 0;
            else
                n = $urandom_range(0, 16);
            if (n > 0)
            begin
                results.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            results.ready <= 1'b1;
            do @(posedge clk); while (!(results.valid && results.ready));
            taken++;
        end
    end

    bit burst = 1'b0;

    task automatic send_beat(input spdh_pkg::kind_t k, input int f, input int t, input int w);
        int n;
        n = burst ? 0 : $urandom_range(0, 16);
        if (n > 0)
        begin
            items.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        items.kind <= k;
        items.from_vertex <= 6'(f);
        items.to_vertex <= 6'(t);
        items.weight <= 16'(w);
        items.valid <= 1'b1;
        do @(posedge clk); while (!(items.valid && items.ready));
        items_sent++;
        if (k == spdh_pkg::KIND_RUN)
            runs_sent++;
    endtask

    task automatic drain();
        items.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int v);
        drain();
        cfg_write <= 1'b1;
        cfg_data <= 7'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_weight();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 16'hFFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    initial begin
        int nv, f, t, sel;
        int settings[8];
        settings = '{64, 7, 1, 33, 127, 0, 2, 16};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_beat(spdh_pkg::KIND_RUN, 0, 0, 0);
        send_beat(spdh_pkg::KIND_ADD, 0, 1, 0);
        send_beat(spdh_pkg::KIND_ADD, 0, 1, 16'hFFFF);
        send_beat(spdh_pkg::KIND_ADD, 1, 2, 16'hFFFF);
        send_beat(spdh_pkg::KIND_ADD, 0, 2, 5);
        send_beat(spdh_pkg::KIND_ADD, 63, 0, 1);
        send_beat(spdh_pkg::KIND_ADD, 0, 63, 16'hAAAA);
        send_beat(spdh_pkg::KIND_ADD, 5, 5, 3);
        send_beat(spdh_pkg::KIND_ADD, 2, 63, 16'h5555);
        send_beat(spdh_pkg::KIND_RUN, 0, 0, 0);
        send_beat(spdh_pkg::KIND_RUN, 63, 63, 16'hFFFF);
        send_beat(spdh_pkg::kind_t'(2'd3), 63, 63, 16'hFFFF);
        set_vertex_count(1);
        send_beat(spdh_pkg::KIND_RUN, 0, 0, 0);
        send_beat(spdh_pkg::KIND_RUN, 5, 0, 0);
        set_vertex_count(3);
        send_beat(spdh_pkg::KIND_RUN, 1, 0, 0);
        send_beat(spdh_pkg::KIND_RUN, 3, 0, 0);
        send_beat(spdh_pkg::KIND_CLEAR, 0, 0, 0);
        send_beat(spdh_pkg::KIND_RUN, 0, 0, 0);

        // random phases over several vertex counts
        foreach (settings[i])
        begin
            set_vertex_count(settings[i]);
            nv = settings[i] == 0 ? 1 : (settings[i] > 64 ? 64 : settings[i]);
            burst = (i % 3 == 2);
            send_beat(spdh_pkg::KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), 0);
            for (int j = 0; j < 8; j++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                begin
                    f = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nv-1);
                    t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nv-1);
                    send_beat(spdh_pkg::KIND_ADD, f, t, pick_weight());
                end
                else if (sel < 90)
                    send_beat(spdh_pkg::KIND_RUN, $urandom_range(0, nv), $urandom_range(0, 63),
                              $urandom_range(0, 16'hFFFF));
                else if (sel < 95)
                    send_beat(spdh_pkg::kind_t'(2'd3), $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 16'hFFFF));
                else
                    send_beat(spdh_pkg::KIND_CLEAR, 0, 0, 0);
            end
            send_beat(spdh_pkg::KIND_RUN, $urandom_range(0, nv-1), 0, 0);
        end
        burst = 1'b0;

        // small graph after a clear
        set_vertex_count(8);
        send_beat(spdh_pkg::KIND_CLEAR, 0, 0, 0);
        send_beat(spdh_pkg::KIND_ADD, 0, 7, 9);
        send_beat(spdh_pkg::KIND_RUN, 0, 0, 0);

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d items (%0d runs) and %0d result beats in %0d cycles",
                 items_sent, runs_sent, beats_checked, cycles);
        $display("vertex counts 0..127 incl. extremes, unused kind, long output stall");
        if (fails == 0)
            $display("PASS shortest_path_dijkstra_heap");
        else
            $display("FAIL shortest_path_dijkstra_heap");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/spdh_pkg.sv
hw/rtl/spdh_in_if.sv
hw/rtl/spdh_out_if.sv
hw/rtl/spdh_ctrl.sv
hw/rtl/spdh_dp.sv
hw/rtl/shortest_path_dijkstra_heap.sv
test/spdh_checker.sv
test/tb_top.sv
